// ----- rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check prop at every rising edge outside reset
`define CHK_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// check that cond implies prop in the same cycle
`define CHK_IMPLY(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// check that cond implies prop in the next cycle
`define CHK_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// ----- rtl/swrm_pkg.sv -----
package swrm_pkg;

	localparam int VAL_W  = 32;
	localparam int CNT7_W = 7;
	localparam int IN_W   = 40;
	localparam int OUT_W  = 80;

	localparam logic [1:0] OP_PUSH = 2'd0;
	localparam logic [1:0] OP_POP  = 2'd1;
	localparam logic [1:0] OP_PEEK = 2'd2;

	localparam logic [1:0] ERR_OK        = 2'd0;
	localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
	localparam logic [1:0] ERR_UNDERFLOW = 2'd2;

	typedef struct packed {
		logic accept;
		logic fetch;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic in_pop;
	} status_t;

endpackage

// ----- rtl/swrm_ctrl.sv -----
module swrm_ctrl
	import swrm_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  status_t status,
	output cmd_t    cmd
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_FETCH  = 2'd1;
	localparam logic [1:0] S_RESULT = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d      = state_q;
		cmd.accept   = 1'b0;
		cmd.fetch    = 1'b0;
		cmd.load_out = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = status.in_pop ? S_FETCH : S_RESULT;
				end
			end
			S_FETCH: begin
				cmd.fetch = 1'b1;
				state_d   = S_RESULT;
			end
			S_RESULT: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/swrm_datapath.sv -----
module swrm_datapath
	import swrm_pkg::*;
#(
	parameter int STACK_DEPTH = 64,
	localparam int CW = $clog2(STACK_DEPTH + 1),
	localparam int AW = $clog2(STACK_DEPTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	output status_t          status,
	input  logic [IN_W-1:0]  in_data,
	output logic [OUT_W-1:0] out_data
);

	logic signed [VAL_W-1:0] val_mem [STACK_DEPTH];
	logic signed [VAL_W-1:0] min_mem [STACK_DEPTH];

	logic [CW-1:0]           cnt_q;
	logic [CW-1:0]           mcnt_q;
	logic signed [VAL_W-1:0] top_q;
	logic signed [VAL_W-1:0] mtop_q;
	logic signed [VAL_W-1:0] rd_val_q;
	logic signed [VAL_W-1:0] rd_min_q;
	logic                    pop_q;
	logic                    mpop_q;
	logic [1:0]              err_q;
	logic [OUT_W-1:0]        out_q;

	logic [1:0]              op;
	logic signed [VAL_W-1:0] val;
	logic                    full;
	logic                    empty;
	logic                    do_push;
	logic                    do_pop;
	logic                    min_push;
	logic                    min_pop;
	logic [1:0]              acc_err;
	logic [CW-1:0]           rd_cnt;
	logic [CW-1:0]           rd_mcnt;
	logic signed [VAL_W-1:0] res_top;
	logic signed [VAL_W-1:0] res_min;
	logic [CW+CNT7_W-1:0]    cnt_ext;

	assign op    = in_data[1:0];
	assign val   = signed'(in_data[VAL_W+1:2]);
	assign full  = (cnt_q == CW'(STACK_DEPTH));
	assign empty = (cnt_q == '0);

	assign do_push  = (op == OP_PUSH) && !full;
	assign do_pop   = (op == OP_POP) && !empty;
	assign min_push = do_push &&
		((mcnt_q == '0) || ((val <= mtop_q) && (mcnt_q != CW'(STACK_DEPTH))));
	assign min_pop  = do_pop && (mcnt_q != '0) && (mtop_q == top_q);

	always_comb begin
		if ((op == OP_PUSH) && full) begin
			acc_err = ERR_OVERFLOW;
		end else if ((op == OP_POP) && empty) begin
			acc_err = ERR_UNDERFLOW;
		end else begin
			acc_err = ERR_OK;
		end
	end

	assign rd_cnt  = cnt_q - CW'(2);
	assign rd_mcnt = mcnt_q - CW'(2);

	assign status.in_pop = (op == OP_POP);

	always_ff @(posedge clk) begin
		if (cmd.accept && do_push) begin
			val_mem[cnt_q[AW-1:0]] <= val;
		end
		rd_val_q <= val_mem[rd_cnt[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && min_push) begin
			min_mem[mcnt_q[AW-1:0]] <= val;
		end
		rd_min_q <= min_mem[rd_mcnt[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			mcnt_q <= '0;
			pop_q  <= 1'b0;
			mpop_q <= 1'b0;
			err_q  <= ERR_OK;
		end else if (cmd.accept) begin
			pop_q  <= do_pop;
			mpop_q <= min_pop;
			err_q  <= acc_err;
			if (do_push) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop) begin
				cnt_q <= cnt_q - CW'(1);
			end
			if (min_push) begin
				mcnt_q <= mcnt_q + CW'(1);
			end else if (min_pop) begin
				mcnt_q <= mcnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			if (do_push) begin
				top_q <= val;
			end
			if (min_push) begin
				mtop_q <= val;
			end
		end else if (cmd.fetch) begin
			if (pop_q) begin
				top_q <= rd_val_q;
			end
			if (mpop_q) begin
				mtop_q <= rd_min_q;
			end
		end
	end

	assign res_top = empty ? '0 : top_q;
	assign res_min = (empty || (mcnt_q == '0)) ? '0 : mtop_q;
	assign cnt_ext = {{CNT7_W{1'b0}}, cnt_q};

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q <= {6'b0, err_q, empty, cnt_ext[CNT7_W-1:0], res_min, res_top};
		end
	end

	assign out_data = out_q;

endmodule

// ----- rtl/stack_with_running_minimum.sv -----
// Min stack: LIFO of signed 32-bit values with the running minimum of held values.
// Push and peek go from acceptance to the result state; pop first passes a fetch
// state, set by the registered read of the value and min memories in the pop path.
// Items are taken one at a time: the next only after the last result is loaded.
// Reset (arst_n low, asynchronous): stack and min stack empty, no result pending;
// memory contents are not cleared.
module stack_with_running_minimum
	import swrm_pkg::*;
#(
	parameter int STACK_DEPTH = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// operation[1:0], push_value[33:2], zero[39:34]
	input  logic [IN_W-1:0]  s_axis_tdata,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// top_value[31:0], min_value[63:32], entry_count[70:64], is_empty[71],
	// error_code[73:72], zero[79:74]
	output logic [OUT_W-1:0] m_axis_tdata
);

	cmd_t    cmd;
	status_t status;

	swrm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.status    (status),
		.cmd       (cmd)
	);

	swrm_datapath #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.in_data  (s_axis_tdata),
		.out_data (m_axis_tdata)
	);

endmodule

// ----- rtl/swrm_checker.sv -----
`include "assert_macros.svh"

module swrm_checker
	import swrm_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             s_axis_tvalid,
	input logic             s_axis_tready,
	input logic [IN_W-1:0]  s_axis_tdata,
	input logic             m_axis_tvalid,
	input logic             m_axis_tready,
	input logic [OUT_W-1:0] m_axis_tdata
);

	`CHK_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped or changed while stalled")
	`CHK_NEXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready, "item accepted while previous still in work")
	`CHK_IMPLY(a_empty_zero, m_axis_tvalid && m_axis_tdata[71], (m_axis_tdata[31:0] == 32'd0) && (m_axis_tdata[63:32] == 32'd0), "empty stack reports nonzero top or min")
	`CHK_IMPLY(a_err_code, m_axis_tvalid, m_axis_tdata[73:72] != 2'd3, "undefined error code")

endmodule

bind stack_with_running_minimum swrm_checker u_swrm_checker (.*);

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
	import swrm_pkg::*;

	localparam int DEPTH = 64;
	localparam int RANDOM_PER_PHASE = 275;
	localparam int DRAIN_CYCLES = 12;
	localparam int CYCLE_LIMIT = 300000;
	localparam logic [1:0] OP_SPARE = 2'd3;

	typedef enum logic [1:0] {
		MODE_FILL,
		MODE_DRAIN,
		MODE_MIXED,
		MODE_DESCEND
	} traffic_mode_t;

	typedef struct packed {
		logic [1:0]         error_code;
		logic               is_empty;
		logic [6:0]         entry_count;
		logic signed [31:0] min_value;
		logic signed [31:0] top_value;
	} stack_view_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] value;
		logic        typed;
		stack_view_t view;
	} op_row_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [IN_W-1:0]  s_axis_tdata = '0;
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;

	logic signed [31:0] held_values[DEPTH];
	logic signed [31:0] held_mins[DEPTH];
	int                 n_values = 0;
	int                 n_mins = 0;

	stack_view_t expected_views[$];
	op_row_t     directed_ops[$];
	int          mismatches = 0;
	int          cycle_count = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;

	stack_with_running_minimum #(
		.STACK_DEPTH(DEPTH)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	function automatic stack_view_t step_min_stack(input logic [1:0] op,
			input logic signed [31:0] val);
		stack_view_t v;
		v = '0;
		v.error_code = ERR_OK;
		if (op == OP_PUSH) begin
			if (n_values >= DEPTH) begin
				v.error_code = ERR_OVERFLOW;
			end else begin
				held_values[n_values] = val;
				n_values++;
				if (n_mins == 0 || val <= held_mins[n_mins-1]) begin
					if (n_mins < DEPTH) begin
						held_mins[n_mins] = val;
						n_mins++;
					end
				end
			end
		end else if (op == OP_POP) begin
			if (n_values == 0) begin
				v.error_code = ERR_UNDERFLOW;
			end else begin
				if (n_mins > 0 && held_mins[n_mins-1] == held_values[n_values-1])
					n_mins--;
				n_values--;
			end
		end
		v.top_value = (n_values > 0) ? held_values[n_values-1] : 32'sd0;
		v.min_value = (n_values > 0 && n_mins > 0) ? held_mins[n_mins-1] : 32'sd0;
		v.entry_count = n_values[6:0];
		v.is_empty = (n_values == 0);
		return v;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %h, actual %h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		stack_view_t got;
		stack_view_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[$bits(stack_view_t)-1:0];
			if (expected_views.size() == 0) begin
				$error("result item with none expected, tdata %h", m_axis_tdata);
				mismatches++;
			end else begin
				want = expected_views.pop_front();
				check_field("top_value", want.top_value, got.top_value);
				check_field("min_value", want.min_value, got.min_value);
				check_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
				check_field("is_empty", 32'(want.is_empty), 32'(got.is_empty));
				check_field("error_code", 32'(want.error_code), 32'(got.error_code));
			end
		end
	end

	task automatic add_row(input logic [1:0] op, input logic [31:0] value,
			input logic typed, input logic [31:0] top, input logic [31:0] min,
			input int count, input logic [1:0] err);
		op_row_t row;
		row.op = op;
		row.value = value;
		row.typed = typed;
		row.view.top_value = top;
		row.view.min_value = min;
		row.view.entry_count = count[6:0];
		row.view.is_empty = (count == 0);
		row.view.error_code = err;
		directed_ops.insert(directed_ops.size(), row);
	endtask

	task automatic send_op(input logic [1:0] op, input logic [31:0] value,
			input logic typed, input stack_view_t typed_view);
		stack_view_t predicted;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(IN_W-34){1'b0}}, value, op};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predicted = step_min_stack(op, value);
		expected_views.insert(expected_views.size(), typed ? typed_view : predicted);
	endtask

	function automatic logic [31:0] pick_value();
		int r;
		r = $urandom_range(0, 7);
		if (r == 0) begin
			case ($urandom_range(0, 3))
				0: return 32'h7FFF_FFFF;
				1: return 32'h8000_0000;
				2: return 32'h0000_0000;
				default: return 32'hFFFF_FFFF;
			endcase
		end
		if (r <= 3)
			return $unsigned($signed($urandom_range(0, 16)) - 8);
		return $urandom;
	endfunction

	function automatic logic [1:0] pick_op(input traffic_mode_t mode);
		int r;
		r = $urandom_range(0, 99);
		case (mode)
			MODE_FILL, MODE_DESCEND: begin
				if (r < 85) return OP_PUSH;
				if (r < 95) return OP_POP;
			end
			MODE_DRAIN: begin
				if (r < 85) return OP_POP;
				if (r < 95) return OP_PUSH;
			end
			default: begin
				if (r < 45) return OP_PUSH;
				if (r < 90) return OP_POP;
			end
		endcase
		return $urandom_range(0, 1) ? OP_PEEK : OP_SPARE;
	endfunction

	initial begin
		int            idle_by_phase[4];
		int            stall_by_phase[4];
		int            sent;
		int            burst;
		traffic_mode_t mode;
		logic [1:0]    op;
		logic [31:0]   value;
		logic [31:0]   falling;

		idle_by_phase = '{0, 82, 0, 31};
		stall_by_phase = '{0, 0, 82, 31};

		add_row(OP_PEEK, 32'h0, 1'b1, 32'h0, 32'h0, 0, ERR_OK);
		add_row(OP_POP, 32'h1234_5678, 1'b1, 32'h0, 32'h0, 0, ERR_UNDERFLOW);
		add_row(OP_SPARE, 32'hFFFF_FFFF, 1'b1, 32'h0, 32'h0, 0, ERR_OK);
		add_row(OP_PUSH, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, ERR_OK);
		add_row(OP_PUSH, 32'h8000_0000, 1'b1, 32'h8000_0000, 32'h8000_0000, 2, ERR_OK);
		add_row(OP_PUSH, 32'h8000_0000, 1'b1, 32'h8000_0000, 32'h8000_0000, 3, ERR_OK);
		add_row(OP_POP, 32'h0, 1'b1, 32'h8000_0000, 32'h8000_0000, 2, ERR_OK);
		add_row(OP_POP, 32'h0, 1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, ERR_OK);
		add_row(OP_PUSH, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2, ERR_OK);
		add_row(OP_PUSH, 32'h0, 1'b1, 32'h0, 32'hFFFF_FFFF, 3, ERR_OK);
		add_row(OP_PUSH, 32'd5, 1'b0, 32'h0, 32'h0, 0, ERR_OK);
		add_row(OP_PUSH, 32'd5, 1'b0, 32'h0, 32'h0, 0, ERR_OK);
		add_row(OP_PUSH, 32'hAAAA_AAAA, 1'b0, 32'h0, 32'h0, 0, ERR_OK);
		add_row(OP_PUSH, 32'h5555_5555, 1'b0, 32'h0, 32'h0, 0, ERR_OK);
		add_row(OP_PEEK, 32'hDEAD_BEEF, 1'b0, 32'h0, 32'h0, 0, ERR_OK);
		add_row(OP_SPARE, 32'h0, 1'b0, 32'h0, 32'h0, 0, ERR_OK);
		repeat (7)
			add_row(OP_POP, 32'h0, 1'b0, 32'h0, 32'h0, 0, ERR_OK);
		add_row(OP_POP, 32'h0, 1'b1, 32'h0, 32'h0, 0, ERR_UNDERFLOW);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_ops[i])
			send_op(directed_ops[i].op, directed_ops[i].value, directed_ops[i].typed,
				directed_ops[i].view);

		falling = $urandom;
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = idle_by_phase[ph];
			recv_stall_pct = stall_by_phase[ph];
			sent = 0;
			while (sent < RANDOM_PER_PHASE) begin
				mode = traffic_mode_t'($urandom_range(0, 3));
				burst = $urandom_range(20, 150);
				if (mode == MODE_DESCEND)
					falling = pick_value();
				for (int k = 0; k < burst && sent < RANDOM_PER_PHASE; k++) begin
					op = pick_op(mode);
					if (op == OP_PUSH && mode == MODE_DESCEND) begin
						falling = falling - $urandom_range(0, 2);
						value = falling;
					end else if (op == OP_PUSH) begin
						value = pick_value();
					end else begin
						value = $urandom;
					end
					send_op(op, value, 1'b0, '0);
					sent++;
				end
			end
		end
		s_axis_tvalid <= 1'b0;

		while (expected_views.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/swrm_pkg.sv
rtl/swrm_ctrl.sv
rtl/swrm_datapath.sv
rtl/stack_with_running_minimum.sv
rtl/swrm_checker.sv
verif/tb_top.sv
